// ----- design/key_matrix_row_debounce_defines.svh -----
// Assertion macros shared by the checker. Each expects clk in scope; the first two also expect rst_n.
`ifndef KEY_MATRIX_ROW_DEBOUNCE_DEFINES_SVH
`define KEY_MATRIX_ROW_DEBOUNCE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define KMRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define KMRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define KMRD_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kmrd_pkg.sv -----
package kmrd_pkg;

  // Fixed field widths.
  localparam int PIN_W = 64;
  localparam int ROW_W = 3;
  localparam int CFG_W = 4;

  // Debounce window after reset.
  localparam logic [CFG_W-1:0] WINDOW_RESET = 4'd8;

  // Default sizes of the history store.
  localparam int ROWS_DEFAULT  = 8;
  localparam int DEPTH_DEFAULT = 8;

  // Slot pointer update request from the datapath.
  typedef struct packed {
    logic advance;   // an in-range row was processed
    logic last_row;  // that row closes a full matrix scan
  } step_t;

endpackage

// ----- design/kmrd_in_if.sv -----
interface kmrd_in_if
  import kmrd_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [PIN_W-1:0] pin_word;

  modport source (output valid, output row_index, output pin_word, input ready);
  modport sink   (input valid, input row_index, input pin_word, output ready);

endinterface

// ----- design/kmrd_out_if.sv -----
interface kmrd_out_if
  import kmrd_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [PIN_W-1:0] debounced_pins;

  modport source (output valid, output out_row, output debounced_pins, input ready);
  modport sink   (input valid, input out_row, input debounced_pins, output ready);

endinterface

// ----- design/kmrd_window.sv -----
module kmrd_window
  import kmrd_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEPTH_DEFAULT,
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
  localparam int WIN_W  = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  step_t             step,
  output logic [WIN_W-1:0]  win,
  output logic [SLOT_W-1:0] slot
);

  logic [CFG_W-1:0]  window_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [WIN_W-1:0]  slot_inc;

  // Clamp the programmed window to the range 1 .. HISTORY_DEPTH.
  always_comb begin
    if (window_r == '0) begin
      win = WIN_W'(1);
    end else if (int'(window_r) > HISTORY_DEPTH) begin
      win = WIN_W'(HISTORY_DEPTH);
    end else begin
      win = WIN_W'(window_r);
    end
  end

  // A pointer at or past the window end selects slot zero.
  assign slot     = (WIN_W'(slot_r) >= win) ? '0 : slot_r;
  assign slot_inc = WIN_W'(slot) + WIN_W'(1);

  // Advance after the last row of a scan; a window write restarts at slot zero.
  always_comb begin
    slot_nxt = slot_r;
    if (cfg_we) begin
      slot_nxt = '0;
    end else if (step.advance) begin
      if (step.last_row) begin
        slot_nxt = (slot_inc >= win) ? '0 : SLOT_W'(slot_inc);
      end else begin
        slot_nxt = slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      slot_r   <= '0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      slot_r <= slot_nxt;
    end
  end

endmodule

// ----- design/kmrd_history.sv -----
module kmrd_history
  import kmrd_pkg::*;
#(
  parameter int ROWS          = ROWS_DEFAULT,
  parameter int HISTORY_DEPTH = DEPTH_DEFAULT,
  localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [RIDX_W-1:0]                     row_sel,
  output logic [HISTORY_DEPTH-1:0][PIN_W-1:0]   rd_data,
  input  logic                                  wr_en,
  input  logic [HISTORY_DEPTH-1:0][PIN_W-1:0]   wr_data
);

  // One register-file entry per row holds all of that row's history slots.
  logic [HISTORY_DEPTH-1:0][PIN_W-1:0] row_mem_r [ROWS];
  logic [ROWS-1:0]                     row_valid_r;

  // A row never written since reset reads as all zero.
  assign rd_data = row_valid_r[row_sel] ? row_mem_r[row_sel] : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem_r[row_sel] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[row_sel] <= 1'b1;
    end
  end

endmodule

// ----- design/key_matrix_row_debounce.sv -----
// Keyboard matrix row debouncer. Each input transfer carries one raw pin word read
// while a matrix row was driven; each result transfer returns that row and the OR
// of the row's readings over the last debounce_window scans, so a press shows at
// once and a release only after a full window without contact. The block takes one
// item per clock when the result side keeps up. Between input transfer and result lie
// an input register, then a single pass that reads the row's history, inserts the
// new reading, ORs the window and writes the row back, then the result register.
// History lives in a per-row register file whose valid bits are cleared by reset,
// so no clearing pass is needed. Writing cfg_wdata restarts the shared slot pointer
// at zero and keeps the history; only write it while no item is in flight. Rows at
// or above ROWS return all-zero pins and leave the history untouched.
module key_matrix_row_debounce
  import kmrd_pkg::*;
#(
  parameter int ROWS          = ROWS_DEFAULT,
  parameter int HISTORY_DEPTH = DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  kmrd_in_if.sink           in_ch,
  kmrd_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int WIN_W  = $clog2(HISTORY_DEPTH + 1);

  logic             s1_valid_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [PIN_W-1:0] s1_pins_r;
  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  logic [PIN_W-1:0] out_pins_r;

  logic                                advance;
  logic                                fire;
  logic                                row_ok;
  step_t                               step;
  logic [WIN_W-1:0]                    win;
  logic [SLOT_W-1:0]                   slot;
  logic [RIDX_W-1:0]                   row_sel;
  logic [HISTORY_DEPTH-1:0][PIN_W-1:0] row_hist;
  logic [HISTORY_DEPTH-1:0][PIN_W-1:0] row_merged;
  logic [PIN_W-1:0]                    pins_or;

  // Handshake: the result register frees up when empty or taken.
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign fire         = s1_valid_r && advance;

  assign row_ok  = int'(s1_row_r) < ROWS;
  assign row_sel = RIDX_W'(s1_row_r);

  assign step.advance  = fire && row_ok;
  assign step.last_row = int'(s1_row_r) == (ROWS - 1);

  kmrd_window #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .step     (step),
    .win      (win),
    .slot     (slot)
  );

  kmrd_history #(
    .ROWS         (ROWS),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk    (clk),
    .rst_n  (rst_n),
    .row_sel(row_sel),
    .rd_data(row_hist),
    .wr_en  (step.advance),
    .wr_data(row_merged)
  );

  // Insert the new reading at the current slot and OR the slots inside the window.
  always_comb begin
    pins_or = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      row_merged[i] = (SLOT_W'(i) == slot) ? s1_pins_r : row_hist[i];
      if (i < int'(win)) begin
        pins_or = pins_or | row_merged[i];
      end
    end
    if (!row_ok) begin
      pins_or = '0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_row_r  <= in_ch.row_index;
      s1_pins_r <= in_ch.pin_word;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_row_r  <= s1_row_r;
      out_pins_r <= pins_or;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_row        = out_row_r;
  assign out_ch.debounced_pins = out_pins_r;

endmodule

// ----- design/kmrd_checker.sv -----
`include "key_matrix_row_debounce_defines.svh"

module kmrd_checker
  import kmrd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] out_row,
  input logic [PIN_W-1:0] debounced_pins
);

  // Reset empties the result register.
  `KMRD_ASSERT_RESET(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

  // With the result register empty, the input side must take a transfer.
  `KMRD_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

  // A new result needs an input transfer that came in through the input register.
  `KMRD_ASSERT_IMP(a_result_has_source, $rose(out_valid), $past(in_valid && in_ready, 2), "result without input transfer")

  // A stalled result holds its payload.
  `KMRD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_row) && $stable(debounced_pins), "stalled result changed")

endmodule

bind key_matrix_row_debounce kmrd_checker u_kmrd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_row       (out_ch.out_row),
  .debounced_pins(out_ch.debounced_pins)
);

// ----- bench/key_matrix_row_debounce_tb.sv -----
module key_matrix_row_debounce_tb
  import kmrd_pkg::*;
;

  localparam int ROWS           = ROWS_DEFAULT;
  localparam int DEPTH          = DEPTH_DEFAULT;
  localparam int STALL_LIMIT    = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int REPORT_MAX     = 10;
  localparam logic [CFG_W-1:0] WINDOW_SWEEP [11] =
    '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd15, 4'd12};

  // One debounced row as it should come out of the block.
  typedef struct {
    logic [ROW_W-1:0] row;
    logic [PIN_W-1:0] pins;
  } debounced_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  kmrd_in_if  in_ch ();
  kmrd_out_if out_ch ();

  key_matrix_row_debounce #(
    .ROWS          (ROWS),
    .HISTORY_DEPTH (DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted state of the debouncer.
  logic [PIN_W-1:0] row_history [ROWS][DEPTH];
  int unsigned      scan_slot;
  logic [CFG_W-1:0] window_setting;

  debounced_t  debounced_q [$];
  int unsigned error_count;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned hold_request;
  int unsigned quiet_cycles;

  always #5 clk = ~clk;

  // Insert one reading into the predicted history and return the OR over the window.
  function automatic logic [PIN_W-1:0] predict_debounce(input logic [ROW_W-1:0] row,
                                                        input logic [PIN_W-1:0] pins);
    int unsigned      win;
    int unsigned      slot;
    logic [PIN_W-1:0] acc;
    win  = (window_setting == 0) ? 1 :
           ((int'(window_setting) > DEPTH) ? DEPTH : int'(window_setting));
    slot = (scan_slot >= win) ? 0 : scan_slot;
    acc  = '0;
    if (int'(row) < ROWS) begin
      row_history[row][slot] = pins;
      for (int i = 0; i < win; i++) begin
        acc |= row_history[row][i];
      end
      if (int'(row) == ROWS - 1) begin
        slot = slot + 1;
        if (slot >= win) begin
          slot = 0;
        end
      end
      scan_slot = slot;
    end
    return acc;
  endfunction

  // Pin words: empty, dense, a single key, or a sparse mix.
  function automatic logic [PIN_W-1:0] random_pins();
    logic [PIN_W-1:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return '0;
      1: return full;
      2: return 64'd1 << $urandom_range(0, PIN_W - 1);
      default: return full & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  // Offer one reading, optionally after an idle burst, and record its expected result.
  task automatic send_reading(input logic [ROW_W-1:0] row, input logic [PIN_W-1:0] pins);
    int unsigned gap;
    debounced_t  item;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.row_index <= row;
    in_ch.pin_word  <= pins;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    item.row  = row;
    item.pins = predict_debounce(row, pins);
    debounced_q.push_back(item);
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (debounced_q.size() != 0) @(posedge clk);
  endtask

  // Write the window register once the block has gone idle.
  task automatic set_window(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we         <= 1'b0;
    window_setting = value;
    scan_slot      = 0;
  endtask

  // Presses, releases and the clamped window settings on hand-picked words.
  task automatic test_directed_patterns();
    send_reading(3'd0, '1);
    send_reading(3'd7, 64'h8000_0000_0000_0001);
    send_reading(3'd0, '0);
    set_window(4'd1);
    send_reading(3'd0, '0);
    send_reading(3'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_reading(3'd7, '0);
    send_reading(3'd0, 64'h5555_5555_5555_5555);
    // A zero window behaves as a window of one scan.
    set_window(4'd0);
    send_reading(3'd3, 64'h5555_5555_5555_5555);
    send_reading(3'd3, 64'hAAAA_AAAA_AAAA_AAAA);
    // A window above the history depth is clamped to the full depth.
    set_window(4'd15);
    for (int r = 0; r < ROWS; r++) begin
      send_reading(r[ROW_W-1:0], (r == 0) ? '1 : (64'hFF << (8 * r)));
    end
    send_reading(3'd0, '0);
    // Shrinking the window keeps history but restarts the slot.
    set_window(4'd2);
    send_reading(3'd0, '0);
    send_reading(3'd7, '0);
    send_reading(3'd0, '0);
  endtask

  // Full scans in row order with random content, plus stray rows, over each window.
  task automatic test_random_scans();
    int unsigned sent;
    foreach (WINDOW_SWEEP[w]) begin
      set_window(WINDOW_SWEEP[w]);
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 9) == 0) begin
          send_reading(ROW_W'($urandom_range(0, ROWS - 1)), random_pins());
          sent++;
        end else begin
          for (int r = 0; r < ROWS; r++) begin
            send_reading(r[ROW_W-1:0], random_pins());
          end
          sent += ROWS;
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while readings keep coming.
  task automatic test_output_backpressure();
    tx_idle_en   = 1'b0;
    hold_request = LONG_HOLD;
    for (int i = 0; i < 40; i++) begin
      send_reading(ROW_W'(i % ROWS), random_pins());
    end
    tx_idle_en = 1'b1;
  endtask

  // The sender stops until the block has emptied, then resumes.
  task automatic test_sender_drain();
    for (int i = 0; i < 24; i++) begin
      send_reading(ROW_W'(i % ROWS), random_pins());
    end
    drain_results();
    for (int i = 0; i < 24; i++) begin
      send_reading(ROW_W'(i % ROWS), random_pins());
    end
  endtask

  // Back-to-back transfers with neither side idling.
  task automatic test_full_rate();
    set_window(CFG_W'($urandom_range(1, DEPTH)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 250; i++) begin
      send_reading(ROW_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, ROWS - 1)
                                                       : i % ROWS),
                   random_pins());
    end
  endtask

  // Result side: long holds on request, otherwise random stall bursts while enabled.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left    = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(1, 10) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    debounced_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (debounced_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX) begin
          $display("unexpected result: row %0d pins %h", out_ch.out_row,
                   out_ch.debounced_pins);
        end
      end else begin
        want = debounced_q.pop_front();
        if (out_ch.out_row !== want.row || out_ch.debounced_pins !== want.pins) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("mismatch: expected row %0d pins %h, got row %0d pins %h",
                     want.row, want.pins, out_ch.out_row, out_ch.debounced_pins);
          end
        end
      end
    end
  end

  // End the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.row_index = '0;
    in_ch.pin_word  = '0;
    error_count     = 0;
    quiet_cycles    = 0;
    hold_request    = 0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    foreach (row_history[r, s]) begin
      row_history[r][s] = '0;
    end
    scan_slot      = 0;
    window_setting = WINDOW_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_patterns();
    test_random_scans();
    test_output_backpressure();
    test_sender_drain();
    test_full_rate();

    drain_results();
    repeat (10) @(posedge clk);
    error_count += debounced_q.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/kmrd_pkg.sv
design/kmrd_in_if.sv
design/kmrd_out_if.sv
design/kmrd_window.sv
design/kmrd_history.sv
design/key_matrix_row_debounce.sv
design/kmrd_checker.sv
bench/key_matrix_row_debounce_tb.sv
